>>> src/irr_pkg.sv
// Shared widths, reset values and register codes for the intensity to RGB ramp.
package irr_pkg;

	localparam int INTENSITY_W = 32;
	localparam int SAT_W = 31;
	localparam int SCALE_W = 17;
	localparam int SCALE_FRAC = 16;
	localparam int CHAN_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = SAT_W;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [SAT_W-1:0] SAT_RESET = SAT_W'(1);
	localparam logic [SCALE_W-1:0] SCALE_ZERO = '0;
	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC;
	localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SATURATION = 3'd0,
		REG_RED_LOW    = 3'd1,
		REG_GREEN_LOW  = 3'd2,
		REG_BLUE_LOW   = 3'd3,
		REG_RED_HIGH   = 3'd4,
		REG_GREEN_HIGH = 3'd5,
		REG_BLUE_HIGH  = 3'd6
	} cfg_reg_t;

endpackage

>>> src/intensity_to_rgb_ramp.sv
// Top level: maps a signed intensity stream onto a configurable linear RGB color ramp.
// Throughput: one transaction per cycle unless out_stall backs up a full pipeline.
// Each divider stage after the first resolves one quotient bit.
// Backpressure: a stage advances when it or any stage after it is empty, so bubbles fill.
// Reset: clears all pipeline valid bits and loads the register defaults
// (saturation 1, low scales 0, high scales 65536).
module intensity_to_rgb_ramp #(
	parameter int FRACTION_BITS = irr_pkg::FRACTION_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [irr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [irr_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [irr_pkg::INTENSITY_W-1:0] intensity,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [irr_pkg::CHAN_W-1:0]             red,
	output logic [irr_pkg::CHAN_W-1:0]             green,
	output logic [irr_pkg::CHAN_W-1:0]             blue
);

	localparam int FB = FRACTION_BITS;
	localparam int NS = FB + 4;

	logic [irr_pkg::SAT_W-1:0]   saturation_q;
	logic [irr_pkg::SCALE_W-1:0] red_low_q;
	logic [irr_pkg::SCALE_W-1:0] green_low_q;
	logic [irr_pkg::SCALE_W-1:0] blue_low_q;
	logic [irr_pkg::SCALE_W-1:0] red_high_q;
	logic [irr_pkg::SCALE_W-1:0] green_high_q;
	logic [irr_pkg::SCALE_W-1:0] blue_high_q;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] rdy;
	logic [FB:0]   frac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saturation_q <= irr_pkg::SAT_RESET;
			red_low_q    <= irr_pkg::SCALE_ZERO;
			green_low_q  <= irr_pkg::SCALE_ZERO;
			blue_low_q   <= irr_pkg::SCALE_ZERO;
			red_high_q   <= irr_pkg::SCALE_ONE;
			green_high_q <= irr_pkg::SCALE_ONE;
			blue_high_q  <= irr_pkg::SCALE_ONE;
		end else if (cfg_we) begin
			unique case (irr_pkg::cfg_reg_t'(cfg_index))
				irr_pkg::REG_SATURATION: saturation_q <= cfg_data;
				irr_pkg::REG_RED_LOW:    red_low_q    <= cfg_data[irr_pkg::SCALE_W-1:0];
				irr_pkg::REG_GREEN_LOW:  green_low_q  <= cfg_data[irr_pkg::SCALE_W-1:0];
				irr_pkg::REG_BLUE_LOW:   blue_low_q   <= cfg_data[irr_pkg::SCALE_W-1:0];
				irr_pkg::REG_RED_HIGH:   red_high_q   <= cfg_data[irr_pkg::SCALE_W-1:0];
				irr_pkg::REG_GREEN_HIGH: green_high_q <= cfg_data[irr_pkg::SCALE_W-1:0];
				irr_pkg::REG_BLUE_HIGH:  blue_high_q  <= cfg_data[irr_pkg::SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage k may load if any stage from k onward is empty, or the output drains
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = !out_stall || !(&vld_s[NS-1:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_s[NS-1];

	irr_div #(.FRACTION_BITS(FB)) u_div (
		.clk       (clk),
		.en        (rdy[FB:0]),
		.intensity (intensity),
		.saturation(saturation_q),
		.frac      (frac)
	);

	irr_blend #(.FRACTION_BITS(FB)) u_red (
		.clk (clk),
		.en  (rdy[FB+3:FB+1]),
		.frac(frac),
		.lo  (red_low_q),
		.hi  (red_high_q),
		.chan(red)
	);

	irr_blend #(.FRACTION_BITS(FB)) u_green (
		.clk (clk),
		.en  (rdy[FB+3:FB+1]),
		.frac(frac),
		.lo  (green_low_q),
		.hi  (green_high_q),
		.chan(green)
	);

	irr_blend #(.FRACTION_BITS(FB)) u_blue (
		.clk (clk),
		.en  (rdy[FB+3:FB+1]),
		.frac(frac),
		.lo  (blue_low_q),
		.hi  (blue_high_q),
		.chan(blue)
	);

	a_drain_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s[0] && out_valid && out_stall))
		else $error("input stalled with a bubble in the pipeline");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[0])
		else $error("accepted transaction lost at first stage");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(!vld_s[NS-2] && (!out_valid || !out_stall)) |=> !out_valid)
		else $error("output valid without a transaction behind it");

endmodule

>>> src/irr_div.sv
// Pipelined restoring divider: clamped fraction intensity / saturation, one quotient bit per stage.
module irr_div #(
	parameter int FRACTION_BITS = irr_pkg::FRACTION_BITS_DEF
) (
	input  logic                                   clk,
	input  logic [FRACTION_BITS:0]                 en,
	input  logic signed [irr_pkg::INTENSITY_W-1:0] intensity,
	input  logic [irr_pkg::SAT_W-1:0]              saturation,
	output logic [FRACTION_BITS:0]                 frac
);

	localparam int FB = FRACTION_BITS;
	localparam int SW = irr_pkg::SAT_W;
	localparam logic [FB:0] FRAC_ONE = (FB+1)'(1) << FB;

	logic [SW-1:0] dvs;
	logic          zero_s [0:FB];
	logic          one_s  [0:FB];
	logic [SW-1:0] rem_s  [0:FB-1];
	logic [FB-1:0] q_s    [1:FB];

	assign dvs = (saturation == '0) ? SW'(1) : saturation;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			zero_s[0] <= intensity[irr_pkg::INTENSITY_W-1] || (intensity == '0);
			one_s[0]  <= intensity[SW-1:0] >= dvs;
			rem_s[0]  <= intensity[SW-1:0];
		end
	end

	for (genvar i = 1; i <= FB; i++) begin : g_stage
		logic [SW:0] r2;
		logic [SW:0] diff;
		logic        ge;

		assign r2   = {rem_s[i-1], 1'b0};
		assign ge   = r2 >= {1'b0, dvs};
		assign diff = r2 - {1'b0, dvs};

		always_ff @(posedge clk) begin
			if (en[i]) begin
				zero_s[i] <= zero_s[i-1];
				one_s[i]  <= one_s[i-1];
			end
		end

		if (i == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en[i]) begin
					q_s[i] <= {{(FB-1){1'b0}}, ge};
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[i]) begin
					q_s[i] <= {q_s[i-1][FB-2:0], ge};
				end
			end
		end

		if (i < FB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[i]) begin
					rem_s[i] <= ge ? diff[SW-1:0] : r2[SW-1:0];
				end
			end
		end
	end

	always_comb begin
		priority if (zero_s[FB]) begin
			frac = '0;
		end else if (one_s[FB]) begin
			frac = FRAC_ONE;
		end else begin
			frac = {1'b0, q_s[FB]};
		end
	end

endmodule

>>> src/irr_blend.sv
// One color channel: linear blend of low and high scale, scaled to a byte with rounding.
module irr_blend #(
	parameter int FRACTION_BITS = irr_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic [2:0]                    en,
	input  logic [FRACTION_BITS:0]        frac,
	input  logic [irr_pkg::SCALE_W-1:0]   lo,
	input  logic [irr_pkg::SCALE_W-1:0]   hi,
	output logic [irr_pkg::CHAN_W-1:0]    chan
);

	localparam int FB = FRACTION_BITS;
	localparam int PW = FB + 1 + irr_pkg::SCALE_W;
	localparam int XW = PW + irr_pkg::CHAN_W;
	localparam int SH = FB + irr_pkg::SCALE_FRAC;
	localparam int CW = XW - SH;
	localparam logic [FB:0] FRAC_ONE = (FB+1)'(1) << FB;
	localparam logic [XW-1:0] HALF = XW'(1) << (SH - 1);

	logic [FB:0]   inv;
	logic [PW-1:0] p_hi_s1;
	logic [PW-1:0] p_lo_s1;
	logic [PW-1:0] sum;
	logic [XW-1:0] x_s2;
	logic [CW-1:0] c;
	logic [irr_pkg::CHAN_W-1:0] chan_s3;

	assign inv = FRAC_ONE - frac;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_hi_s1 <= PW'(frac) * PW'(hi);
			p_lo_s1 <= PW'(inv) * PW'(lo);
		end
	end

	// fs * 255 + half, as fs * 256 - fs
	assign sum = p_hi_s1 + p_lo_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s2 <= {sum, {irr_pkg::CHAN_W{1'b0}}} - XW'(sum) + HALF;
		end
	end

	assign c = x_s2[XW-1:SH];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			chan_s3 <= (c > CW'(irr_pkg::CHAN_MAX)) ? irr_pkg::CHAN_MAX
				: c[irr_pkg::CHAN_W-1:0];
		end
	end

	assign chan = chan_s3;

endmodule
